// ===== design/ptt_pkg.sv =====
// ============================================================================
// ptt_pkg - shared types and constants of the periodic task timer table
// Holds the command and result item layouts, the token that travels along
// the row of slot cells, and the sizing constants of the table.
// ============================================================================
package ptt_pkg;

    // Table sizing.
    localparam int MAX_TASKS   = 16;
    localparam int TIME_BITS   = 32;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_RESULTS + 1);
    localparam int ID_BITS   = 4;
    localparam int CMP_BITS  = (SLOT_BITS > ID_BITS) ? SLOT_BITS : ID_BITS;
    localparam int WIDE_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    // Command codes.
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_SETPER = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOTASK = 2'd2,
        ST_IDLE   = 2'd3
    } status_t;

    // Input item.
    typedef struct packed {
        kind_t               kind;
        logic [31:0]         now;
        logic [ID_BITS-1:0]  task_id;
        logic                run_once;
        logic [31:0]         period;
        logic [31:0]         first_delay;
    } cmd_t;

    // Result item.
    typedef struct packed {
        status_t             status;
        logic [ID_BITS-1:0]  slot_id;
        logic                fired;
        logic                last;
    } res_t;

    // Token handed from cell to cell while a command is in progress.
    typedef struct packed {
        logic                valid;
        kind_t               kind;
        time_t               now;
        logic [ID_BITS-1:0]  task_id;
        logic                run_once;
        time_t               period;
        time_t               add_due;
        logic                done;
        slot_t               slot;
        cnt_t                fire_cnt;
    } tok_t;

    // Firing report of one cell.
    typedef struct packed {
        logic  fire;
        slot_t slot;
    } evt_t;

    // Reduce a 32-bit time value to the table's time width.
    function automatic time_t to_time(input logic [31:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return w[TIME_BITS-1:0];
    endfunction

    // Slot index as it appears in the 4-bit id field of a result.
    function automatic logic [ID_BITS-1:0] slot_to_id(input slot_t s);
        logic [CMP_BITS-1:0] w;
        w = CMP_BITS'(s);
        return w[ID_BITS-1:0];
    endfunction

endpackage

// ===== design/ptt_cell.sv =====
// ============================================================================
// ptt_cell - one task slot of the timer table
// Holds a slot's state and acts on the command token as it passes through,
// then hands the token on to the next cell in the following cycle.
// ============================================================================
module ptt_cell
    import ptt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  slot_t idx,
    input  tok_t  tok_in,
    output tok_t  tok_out,
    output evt_t  evt
);

    logic  valid_reg;
    logic  valid_next;
    logic  run_once_reg;
    logic  run_once_next;
    time_t due_reg;
    time_t due_next;
    time_t period_reg;
    time_t period_next;
    tok_t  tok_reg;
    tok_t  tok_next;

    logic  hit_add;
    logic  hit_id;
    logic  hit_fire;

    // Decide whether this slot takes part in the passing command.
    always_comb
    begin
        hit_add  = tok_in.valid && (tok_in.kind == KIND_ADD) && !tok_in.done && !valid_reg;
        hit_id   = tok_in.valid && ((tok_in.kind == KIND_STOP) || (tok_in.kind == KIND_SETPER))
                   && (CMP_BITS'(idx) == CMP_BITS'(tok_in.task_id)) && valid_reg;
        hit_fire = tok_in.valid && (tok_in.kind == KIND_TICK) && valid_reg
                   && (due_reg <= tok_in.now) && (tok_in.fire_cnt < CNT_BITS'(MAX_RESULTS));
    end

    // Slot state update.
    always_comb
    begin
        valid_next    = valid_reg;
        run_once_next = run_once_reg;
        due_next      = due_reg;
        period_next   = period_reg;
        if (hit_add)
        begin
            valid_next    = 1'b1;
            run_once_next = tok_in.run_once;
            due_next      = tok_in.add_due;
            period_next   = tok_in.period;
        end
        if (hit_id && (tok_in.kind == KIND_STOP))
        begin
            valid_next = 1'b0;
        end
        if (hit_id && (tok_in.kind == KIND_SETPER))
        begin
            period_next = tok_in.period;
        end
        if (hit_fire)
        begin
            due_next = tok_in.now + period_reg;
            if (run_once_reg)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Token passed on to the neighbour.
    always_comb
    begin
        tok_next = tok_in;
        if (hit_add || hit_id)
        begin
            tok_next.done = 1'b1;
            tok_next.slot = idx;
        end
        if (hit_fire)
        begin
            tok_next.fire_cnt = tok_in.fire_cnt + cnt_t'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Slot payload, meaningful only while the slot is live.
    always_ff @(posedge clk)
    begin
        run_once_reg <= run_once_next;
        due_reg      <= due_next;
        period_reg   <= period_next;
    end

    // The report is all zero unless this cell fires, so reports can be ORed.
    assign tok_out  = tok_reg;
    assign evt.fire = hit_fire;
    assign evt.slot = hit_fire ? idx : '0;

endmodule

// ===== design/periodic_task_timer_table_top.sv =====
// ============================================================================
// periodic_task_timer_table_top - table of periodic and run-once timed tasks
// An accepted item's token is registered, walks the row of slot cells, and the
// final result is registered from the token leaving the last cell; busy falls
// in that cycle, so no new item is taken until the one before it is through.
// A tick reports each firing as the sweep finds the next one or ends.
// Reset: asynchronous, leaves the table empty; results cannot be stalled.
// ============================================================================
module periodic_task_timer_table_top
    import ptt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic result_valid,
    output res_t result
);

    tok_t  launch_reg;
    tok_t  launch_next;
    logic  busy_reg;
    logic  busy_next;
    logic  pend_valid_reg;
    logic  pend_valid_next;
    slot_t pend_slot_reg;
    slot_t pend_slot_next;
    logic  result_valid_reg;
    logic  result_valid_next;
    res_t  result_reg;
    res_t  result_next;

    tok_t  tok_w [0:MAX_TASKS];
    evt_t  evt_w [0:MAX_TASKS-1];
    evt_t  evt_any;
    tok_t  tok_end;
    logic  accept;

    assign accept   = start && !busy_reg;
    assign tok_w[0] = launch_reg;
    assign tok_end  = tok_w[MAX_TASKS];

    // Row of slot cells.
    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_cell
        ptt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (slot_t'(g)),
            .tok_in  (tok_w[g]),
            .tok_out (tok_w[g+1]),
            .evt     (evt_w[g])
        );
    end

    // Only the cell holding the token can fire, so the reports merge by OR.
    always_comb
    begin
        evt_any = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            evt_any = evt_any | evt_w[i];
        end
    end

    // Build the token for an accepted item.
    always_comb
    begin
        launch_next          = '0;
        launch_next.valid    = accept;
        launch_next.kind     = cmd.kind;
        launch_next.now      = to_time(cmd.now);
        launch_next.task_id  = cmd.task_id;
        launch_next.run_once = cmd.run_once;
        launch_next.period   = to_time(cmd.period);
        launch_next.add_due  = to_time(cmd.now) + to_time(cmd.first_delay);
    end

    // Busy from acceptance until the token leaves the last cell.
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tok_end.valid)
        begin
            busy_next = 1'b0;
        end
    end

    // Result generation; a firing is held until it is known whether it is the last.
    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = '0;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;

        if (evt_any.fire)
        begin
            if (pend_valid_reg)
            begin
                result_valid_next   = 1'b1;
                result_next.status  = ST_OK;
                result_next.slot_id = slot_to_id(pend_slot_reg);
                result_next.fired   = 1'b1;
                result_next.last    = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = evt_any.slot;
        end

        if (tok_end.valid)
        begin
            result_valid_next = 1'b1;
            result_next.last  = 1'b1;
            pend_valid_next   = 1'b0;
            unique case (tok_end.kind)
                KIND_TICK:
                begin
                    if (pend_valid_reg)
                    begin
                        result_next.status  = ST_OK;
                        result_next.slot_id = slot_to_id(pend_slot_reg);
                        result_next.fired   = 1'b1;
                    end
                    else
                    begin
                        result_next.status = ST_IDLE;
                    end
                end
                KIND_ADD:
                begin
                    if (tok_end.done)
                    begin
                        result_next.status  = ST_OK;
                        result_next.slot_id = slot_to_id(tok_end.slot);
                    end
                    else
                    begin
                        result_next.status = ST_FULL;
                    end
                end
                KIND_STOP, KIND_SETPER:
                begin
                    result_next.status  = tok_end.done ? ST_OK : ST_NOTASK;
                    result_next.slot_id = tok_end.task_id;
                end
                default:
                begin
                    result_next.status = ST_IDLE;
                end
            endcase
        end
    end

    // Control and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg       <= '0;
            busy_reg         <= 1'b0;
            pend_valid_reg   <= 1'b0;
            pend_slot_reg    <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            launch_reg       <= launch_next;
            busy_reg         <= busy_next;
            pend_valid_reg   <= pend_valid_next;
            pend_slot_reg    <= pend_slot_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sim/periodic_task_timer_table_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// periodic_task_timer_table_top_tb - self-checking bench of the task table
// Drives tick, add, stop and set-period items through the start/busy
// handshake. A model of the slot table predicts every result strobe, and
// each strobe is compared field by field with the oldest prediction.
// ============================================================================
module periodic_task_timer_table_top_tb;
    import ptt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 272;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic result_valid;
    res_t result;

    // Model of the slot table.
    logic  slot_live [MAX_TASKS];
    logic  slot_once [MAX_TASKS];
    time_t slot_due  [MAX_TASKS];
    time_t slot_per  [MAX_TASKS];

    // Results still owed by the block, oldest first.
    res_t pending_results[$];

    logic        idle_enabled;
    logic [31:0] sim_clock;
    int          mismatches;
    int          stall_cycles;
    int          item_count;
    int          kind_count [4];
    int          result_count;
    int          firing_count;
    int          full_count;

    periodic_task_timer_table_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Appends one expected result behind the older ones.
    task automatic queue_result(input res_t r);
        pending_results = {pending_results, r};
    endtask

    // Works out the results of one accepted item and updates the model.
    task automatic predict_results(input cmd_t c);
        res_t  r;
        res_t  held;
        logic  have_held;
        logic  found;
        time_t now_t;
        int    fires;

        now_t     = time_t'(c.now);
        r         = '0;
        r.last    = 1'b1;
        have_held = 1'b0;
        found     = 1'b0;
        fires     = 0;
        case (c.kind)
            KIND_ADD:
            begin
                r.status  = ST_FULL;
                r.slot_id = '0;
                for (int i = 0; i < MAX_TASKS; i++)
                begin
                    if (!found && !slot_live[i])
                    begin
                        found        = 1'b1;
                        slot_live[i] = 1'b1;
                        slot_once[i] = c.run_once;
                        slot_per[i]  = time_t'(c.period);
                        slot_due[i]  = time_t'(now_t + time_t'(c.first_delay));
                        r.status     = ST_OK;
                        r.slot_id    = ID_BITS'(i);
                    end
                end
                queue_result(r);
            end
            KIND_STOP, KIND_SETPER:
            begin
                r.slot_id = c.task_id;
                if (int'(c.task_id) >= MAX_TASKS || !slot_live[c.task_id])
                begin
                    r.status = ST_NOTASK;
                end
                else
                begin
                    r.status = ST_OK;
                    if (c.kind == KIND_STOP)
                        slot_live[c.task_id] = 1'b0;
                    else
                        slot_per[c.task_id] = time_t'(c.period);
                end
                queue_result(r);
            end
            default:
            begin
                // A tick: each result is held back until the next firing
                // is known, so that the final one can carry the last flag.
                for (int i = 0; i < MAX_TASKS; i++)
                begin
                    if (fires < MAX_RESULTS && slot_live[i] && slot_due[i] <= now_t)
                    begin
                        slot_due[i] = time_t'(now_t + slot_per[i]);
                        if (slot_once[i])
                            slot_live[i] = 1'b0;
                        if (have_held)
                            queue_result(held);
                        held.status  = ST_OK;
                        held.slot_id = ID_BITS'(i);
                        held.fired   = 1'b1;
                        held.last    = 1'b0;
                        have_held    = 1'b1;
                        fires++;
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    queue_result(held);
                end
                else
                begin
                    r.status = ST_IDLE;
                    queue_result(r);
                end
            end
        endcase
    endtask

    // Checks each result strobe first, then predicts for an item taken at
    // the same edge, so that results always meet the older predictions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                result_count++;
                if (result.fired)
                    firing_count++;
                if (result.status == ST_FULL)
                    full_count++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result status=%0d slot=%0d fired=%0b last=%0b",
                                 $realtime, result.status, result.slot_id, result.fired,
                                 result.last);
                end
                else
                begin
                    res_t want;
                    want = pending_results.pop_front();
                    if (result.status !== want.status || result.slot_id !== want.slot_id ||
                        result.fired !== want.fired || result.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch expected status=%0d slot=%0d fired=%0b last=%0b",
                                     $realtime, want.status, want.slot_id, want.fired,
                                     want.last);
                            $display("%0t:          got      status=%0d slot=%0d fired=%0b last=%0b",
                                     $realtime, result.status, result.slot_id, result.fired,
                                     result.last);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                item_count++;
                kind_count[cmd.kind]++;
                predict_results(cmd);
            end
        end
    end

    // Watchdog on cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding.",
                         pending_results.size());
                $display("periodic_task_timer_table_top_tb: FAIL");
                $finish;
            end
        end
    end

    // Item with every field random, used for noise and for idle cycles.
    function automatic cmd_t noise_cmd();
        cmd_t c;
        c.kind        = kind_t'($urandom_range(0, 3));
        c.now         = $urandom();
        c.task_id     = ID_BITS'($urandom());
        c.run_once    = 1'($urandom());
        c.period      = $urandom();
        c.first_delay = $urandom();
        return c;
    endfunction

    function automatic cmd_t make_cmd(input kind_t k, input logic [31:0] now_v,
                                      input logic [ID_BITS-1:0] id, input logic once,
                                      input logic [31:0] per, input logic [31:0] delay);
        cmd_t c;
        c.kind        = k;
        c.now         = now_v;
        c.task_id     = id;
        c.run_once    = once;
        c.period      = per;
        c.first_delay = delay;
        return c;
    endfunction

    // Sends one item, with an occasional idle gap in front of it, and
    // returns at the edge where the block takes it.
    task automatic send_item(input cmd_t c);
        if (idle_enabled && $urandom_range(0, 99) < 8)
        begin
            start <= 1'b0;
            cmd   <= noise_cmd();
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Ticks, stops and period changes on an empty table.
    task automatic test_empty_table();
        send_item(make_cmd(KIND_TICK, 32'd0, '0, 1'b0, 32'd0, 32'd0));
        send_item(make_cmd(KIND_STOP, 32'd0, ID_BITS'(0), 1'b0, 32'd0, 32'd0));
        send_item(make_cmd(KIND_SETPER, 32'd0, ID_BITS'(15), 1'b0, 32'hFFFF_FFFF, 32'd0));
    endtask

    // Adds with extreme times, firing, period change, wrap of the due time,
    // stop, and a tick on a live task that is not yet due.
    task automatic test_add_and_fire();
        send_item(make_cmd(KIND_ADD, 32'd0, '0, 1'b0, 32'd0, 32'd0));
        send_item(make_cmd(KIND_ADD, 32'hFFFF_FFFF, ID_BITS'(15), 1'b1, 32'hFFFF_FFFF, 32'd1));
        send_item(make_cmd(KIND_TICK, 32'd0, '0, 1'b0, 32'd0, 32'd0));
        send_item(make_cmd(KIND_SETPER, 32'd0, ID_BITS'(0), 1'b0, 32'hFFFF_FFFF, 32'd0));
        send_item(make_cmd(KIND_TICK, 32'hFFFF_FFFF, '0, 1'b0, 32'd0, 32'd0));
        send_item(make_cmd(KIND_STOP, 32'd0, ID_BITS'(0), 1'b0, 32'd0, 32'd0));
        send_item(make_cmd(KIND_ADD, 32'd100, '0, 1'b0, 32'd3, 32'd5));
        send_item(make_cmd(KIND_TICK, 32'd104, '0, 1'b0, 32'd0, 32'd0));
    endtask

    // Fills every slot, tries one add too many, then fires the whole table.
    task automatic test_table_full();
        for (int i = 1; i < MAX_TASKS; i++)
            send_item(make_cmd(KIND_ADD, $urandom_range(0, 1000), ID_BITS'($urandom()), 1'b1,
                               $urandom(), $urandom_range(0, 1000)));
        send_item(make_cmd(KIND_ADD, 32'd0, '0, 1'b0, 32'd1, 32'd1));
        send_item(make_cmd(KIND_TICK, 32'hFFFF_FFFF, '0, 1'b0, 32'd0, 32'd0));
    endtask

    // Mostly well-formed traffic on a time base that moves forward, with
    // some fully random items mixed in; the middle third never idles.
    task automatic test_random_traffic(input int n_items);
        cmd_t c;
        int   pick;
        int   live_ids[$];

        sim_clock = $urandom_range(0, 1000);
        for (int k = 0; k < n_items; k++)
        begin
            idle_enabled = !(k >= n_items / 3 && k < 2 * n_items / 3);
            c    = noise_cmd();
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                // Noise: a random tick or add moves the time base with it.
                if (c.kind == KIND_TICK || c.kind == KIND_ADD)
                    sim_clock = c.now;
            end
            else if (pick < 45)
            begin
                sim_clock = sim_clock + $urandom_range(0, 40);
                c.kind    = KIND_TICK;
                c.now     = sim_clock;
            end
            else if (pick < 70)
            begin
                c.kind = KIND_ADD;
                c.now  = sim_clock;
                if ($urandom_range(0, 9) != 0)
                    c.first_delay = $urandom_range(0, 60);
                if ($urandom_range(0, 9) != 0)
                    c.period = $urandom_range(0, 60);
            end
            else
            begin
                c.kind = (pick < 85) ? KIND_STOP : KIND_SETPER;
                if ($urandom_range(0, 9) != 0)
                    c.period = $urandom_range(0, 60);
                live_ids.delete();
                for (int i = 0; i < MAX_TASKS; i++)
                    if (slot_live[i])
                        live_ids = {live_ids, i};
                if (live_ids.size() != 0 && $urandom_range(0, 3) != 0)
                    c.task_id = ID_BITS'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
            end
            send_item(c);
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        idle_enabled = 1'b1;
        sim_clock    = '0;
        mismatches   = 0;
        stall_cycles = 0;
        item_count   = 0;
        result_count = 0;
        firing_count = 0;
        full_count   = 0;
        for (int k = 0; k < 4; k++)
            kind_count[k] = 0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_once[i] = 1'b0;
            slot_due[i]  = '0;
            slot_per[i]  = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_add_and_fire();
        test_table_full();
        test_random_traffic(RANDOM_ITEMS);

        // Drain: wait for every owed result, then a little longer.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (MAX_TASKS + 8) @(posedge clk);

        $display("Covered %0d items: %0d ticks, %0d adds, %0d stops, %0d period changes.",
                 item_count, kind_count[KIND_TICK], kind_count[KIND_ADD],
                 kind_count[KIND_STOP], kind_count[KIND_SETPER]);
        $display("Checked %0d results: %0d firings, %0d table-full replies, %0d mismatches.",
                 result_count, firing_count, full_count, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("periodic_task_timer_table_top_tb: PASS");
        end
        else
        begin
            $display("periodic_task_timer_table_top_tb: FAIL");
        end
        $finish;
    end

endmodule
